>>> rtl/spg_pkg.sv
// Package for the Sobel/Prewitt gradient stream: widths, codes, defaults,
// state types and the byte clamp used by the gradient unit. No dependencies.
`timescale 1ns / 1ps
package spg_pkg;

   localparam int MAX_LINE_WIDTH_DEF = 1024;
   localparam int CSR_IDX_W          = 2;
   localparam int LINE_W_W           = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd3;

   localparam logic [1:0] MODE_VERT = 2'd0;
   localparam logic [1:0] MODE_HORZ = 2'd1;
   localparam logic [1:0] MODE_L1   = 2'd2;
   localparam logic [1:0] MODE_L2   = 2'd3;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // pixel sequencer states
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_FIRST, S_WAIT1, S_SECOND, S_WAIT2, S_OUT
   } seq_state_type;

   // gradient unit states
   typedef enum logic [2:0] {G_IDLE, G_GRAD, G_SQ, G_ROOT, G_GAIN} grad_state_type;

   typedef struct packed {
      logic [7:0] tl, tc, tr, ml, mr, bl, bc, br;
   } win_type;

   typedef struct packed {
      logic       kernel;
      logic [1:0] mode;
      logic [7:0] gain;
   } cfg_type;

   // Clamp a signed 12-bit sum to 0..255
   function automatic logic [7:0] sat_byte(input logic signed [11:0] v);
      logic [7:0] r;
      if (v < 0) r = 8'd0;
      else if (v > 12'sd255) r = 8'd255;
      else r = v[7:0];
      return r;
   endfunction

endpackage

>>> rtl/spg_if.sv
// Valid/ready stream interfaces for pixel, result and register write beats.
// Depends on nothing.
`timescale 1ns / 1ps
interface spg_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] pixel;
   modport source (output valid, op, pixel, input ready);
   modport sink   (input valid, op, pixel, output ready);
endinterface

interface spg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value;
   logic       frame_last;
   modport source (output valid, value, frame_last, input ready);
   modport sink   (input valid, value, frame_last, output ready);
endinterface

interface spg_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [10:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/spg_line_mem.sv
// Two line stores as one synchronous RAM, each word holding both rows of a
// column. Depends on nothing.
`timescale 1ns / 1ps
module spg_line_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [15:0]              rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [15:0]              wr_data
);
   logic [15:0] mem [DEPTH];

   // write one column, read one column, registered data
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/spg_grad.sv
// Gradient and norm unit: registered stages from window to result byte.
// Depends on spg_pkg.
`timescale 1ns / 1ps
module spg_grad (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  spg_pkg::win_type   win,
   input  spg_pkg::cfg_type   cfg,
   output logic               done,
   output logic [7:0]         result
);
   import spg_pkg::*;

   grad_state_type st_ff, st_in;
   logic signed [8:0] dv_ff, dh_ff;
   logic [7:0] cv_ff, ch_ff;
   logic [16:0] sq_ff;
   logic [8:0] r_ff;
   logic [9:0] bit_ff;
   logic [7:0] res_ff, res_in;
   logic signed [8:0] dv_in, dh_in;
   logic [7:0] cv_in, ch_in;
   logic [16:0] sq_in;
   logic [8:0] r_in;
   logic [9:0] bit_in;
   logic done_in, done_ff;
   logic signed [11:0] gv, gh, l1;
   logic [9:0] wsum_b, wsum_t, wsum_r, wsum_l;
   logic [9:0] trial;
   logic [19:0] trial_sq;
   logic [16:0] rr;
   logic [16:0] prod;

   // weighted column sums
   always_comb begin
      if (cfg.kernel) begin
         wsum_b = {2'b0, win.bc}; wsum_t = {2'b0, win.tc};
         wsum_r = {2'b0, win.mr}; wsum_l = {2'b0, win.ml};
      end else begin
         wsum_b = {1'b0, win.bc, 1'b0}; wsum_t = {1'b0, win.tc, 1'b0};
         wsum_r = {1'b0, win.mr, 1'b0}; wsum_l = {1'b0, win.ml, 1'b0};
      end
      gv = $signed({2'b0, wsum_b} + {4'b0, win.bl} + {4'b0, win.br})
         - $signed({2'b0, wsum_t} + {4'b0, win.tl} + {4'b0, win.tr});
      gh = $signed({2'b0, wsum_r} + {4'b0, win.tr} + {4'b0, win.br})
         - $signed({2'b0, wsum_l} + {4'b0, win.tl} + {4'b0, win.bl});
   end

   assign trial    = {1'b0, r_ff} + bit_ff;
   assign trial_sq = trial * trial;
   assign rr       = {8'b0, r_ff} * {8'b0, r_ff} + {8'b0, r_ff};
   assign prod     = {8'b0, r_ff} * {9'b0, cfg.gain};
   assign l1 = (dv_ff < 0 ? -{{3{dv_ff[8]}}, dv_ff} : {{3{dv_ff[8]}}, dv_ff})
             + (dh_ff < 0 ? -{{3{dh_ff[8]}}, dh_ff} : {{3{dh_ff[8]}}, dh_ff})
             + 12'sd128;

   // sequence the stages; the root takes one bit per cycle
   always_comb begin
      st_in = st_ff; dv_in = dv_ff; dh_in = dh_ff; cv_in = cv_ff; ch_in = ch_ff;
      sq_in = sq_ff; r_in = r_ff; bit_in = bit_ff; res_in = res_ff; done_in = 1'b0;
      case (st_ff)
         G_IDLE: if (start) begin
            cv_in = sat_byte(gv + 12'sd128);
            ch_in = sat_byte(gh + 12'sd128);
            st_in = G_GRAD;
         end
         G_GRAD: begin
            dv_in = $signed({1'b0, cv_ff}) - 9'sd128;
            dh_in = $signed({1'b0, ch_ff}) - 9'sd128;
            st_in = G_SQ;
         end
         G_SQ: begin
            case (cfg.mode)
               MODE_VERT: begin res_in = cv_ff; done_in = 1'b1; st_in = G_IDLE; end
               MODE_HORZ: begin res_in = ch_ff; done_in = 1'b1; st_in = G_IDLE; end
               MODE_L1: begin res_in = sat_byte(l1); done_in = 1'b1; st_in = G_IDLE; end
               default: begin
                  sq_in = 17'(dv_ff * dv_ff) + 17'(dh_ff * dh_ff);
                  r_in = 9'd0; bit_in = 10'd256; st_in = G_ROOT;
               end
            endcase
         end
         G_ROOT: begin
            if ({10'b0, sq_ff} >= trial_sq) r_in = trial[8:0];
            bit_in = bit_ff >> 1;
            if (bit_ff == 10'd1) st_in = G_GAIN;
         end
         G_GAIN: begin
            // round the root, then scale
            if (sq_ff > rr) r_in = r_ff + 9'd1;
            if (sq_ff > rr) st_in = G_GAIN; // applied next cycle
            bit_in = bit_ff;
            if (!(sq_ff > rr)) begin
               res_in = (prod > 17'd255) ? 8'd255 : prod[7:0];
               done_in = 1'b1; st_in = G_IDLE;
            end
            if (sq_ff > rr) sq_in = 17'd0; // keep the next pass from adding again
         end
         default: st_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= G_IDLE; done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; done_ff <= done_in;
      end
      dv_ff <= dv_in; dh_ff <= dh_in; cv_ff <= cv_in; ch_ff <= ch_in;
      sq_ff <= sq_in; r_ff <= r_in; bit_ff <= bit_in; res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

>>> rtl/sobel_prewitt_gradient_stream.sv
// Top level of the 3x3 Sobel/Prewitt gradient stream filter.
// Depends on spg_pkg, the spg interfaces, spg_line_mem and spg_grad.
//
//   channel  dir  beat carries
//   req      in   op, pixel
//   rsp      out  value, frame_last
//   csr      in   index, data (register write)
//
// A pixel passes S_IDLE, S_READ and S_OUT, with S_FIRST/S_WAIT1 for a result
// and S_SECOND/S_WAIT2 for a second; L2 mode adds the bit-serial root.
// Reset is synchronous; a clearing pass then zeroes the line stores, one
// column per cycle over all MAX_LINE_WIDTH columns, with req held off.
// A stalled rsp holds its beat and the sequencer waits with it; no new
// pixel is taken until results drain.
`timescale 1ns / 1ps
module sobel_prewitt_gradient_stream #(
   parameter int MAX_LINE_WIDTH = spg_pkg::MAX_LINE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   spg_req_if.sink   req,
   spg_rsp_if.source rsp,
   spg_csr_if.sink   csr
);
   import spg_pkg::*;

   localparam int AW = $clog2(MAX_LINE_WIDTH);

   seq_state_type st_ff, st_in;
   logic kernel_ff; logic [1:0] mode_ff; logic [10:0] width_ff; logic [7:0] gain_ff;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0] rows_ff, rows_in;
   logic flushing_ff, flushing_in;
   logic [7:0] pix_ff, pix_in;
   logic last_ff, last_in, emit_ff, emit_in, c0_ff, c0_in;
   logic [7:0] w_ff [6];
   logic [7:0] col0, col1;
   logic [15:0] rd_data;
   logic rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [15:0] wr_data;
   logic [12:0] width_eff;
   logic [AW-1:0] cur_col;
   logic start; win_type win; cfg_type cfg;
   logic gdone; logic [7:0] gres;
   logic [7:0] out_ff; logic out_last_ff; logic out_valid_ff;
   logic two_ff, two_in;
   logic accept;

   // register writes
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= 1'b0; mode_ff <= MODE_VERT; width_ff <= 11'd1024; gain_ff <= 8'd15;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_KERNEL: kernel_ff <= csr.data[0];
            CSR_MODE:   mode_ff   <= csr.data[1:0];
            CSR_WIDTH:  width_ff  <= csr.data;
            CSR_GAIN:   gain_ff   <= csr.data[7:0];
            default: ;
         endcase
      end
   end

   // effective width and column
   always_comb begin
      width_eff = {2'b0, width_ff};
      if (width_eff == 13'd0) width_eff = 13'd1;
      if (width_eff > 13'(MAX_LINE_WIDTH)) width_eff = 13'(MAX_LINE_WIDTH);
      cur_col = col_ff;
      if ({{(13-AW){1'b0}}, col_ff} >= width_eff) cur_col = AW'(width_eff - 13'd1);
   end

   assign req.ready = (st_ff == S_IDLE);
   assign accept = req.valid && req.ready;
   assign rd_en = accept; assign rd_addr = cur_col;

   spg_line_mem #(.DEPTH(MAX_LINE_WIDTH)) u_mem (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data));

   assign col0 = (rows_ff >= 2'd2) ? rd_data[15:8] : 8'd0;
   assign col1 = (rows_ff >= 2'd1) ? rd_data[7:0] : 8'd0;

   // write back the shifted column, or zero while clearing
   assign wr_en   = (st_ff == S_READ) || (st_ff == S_CLEAR);
   assign wr_addr = (st_ff == S_CLEAR) ? clr_ff : col_ff;
   assign wr_data = (st_ff == S_CLEAR) ? 16'd0 : {col1, pix_ff};

   assign cfg = '{kernel: kernel_ff, mode: mode_ff, gain: gain_ff};

   // window selection: first result from stored and new columns, else second
   always_comb begin
      if (st_ff == S_READ && !c0_ff) begin
         win = '{tl: w_ff[0], ml: w_ff[1], bl: w_ff[2], tc: w_ff[3], bc: w_ff[5],
                 tr: col0, mr: col1, br: pix_ff};
      end else if (st_ff == S_READ) begin
         win = '{tl: 8'd0, ml: 8'd0, bl: 8'd0, tc: col0, bc: pix_ff,
                 tr: 8'd0, mr: 8'd0, br: 8'd0};
      end else begin
         win = '{tl: w_ff[3], ml: w_ff[4], bl: w_ff[5], tc: col0, bc: pix_ff,
                 tr: 8'd0, mr: 8'd0, br: 8'd0};
      end
   end

   spg_grad u_grad (.clock(clock), .reset(reset), .start(start), .win(win), .cfg(cfg),
      .done(gdone), .result(gres));

   // sequence one pixel
   always_comb begin
      st_in = st_ff; col_in = col_ff; rows_in = rows_ff; flushing_in = flushing_ff;
      pix_in = pix_ff; last_in = last_ff; emit_in = emit_ff; c0_in = c0_ff;
      two_in = two_ff; start = 1'b0; clr_in = clr_ff;
      case (st_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_LINE_WIDTH - 1)) st_in = S_IDLE;
         end
         S_IDLE: if (accept) begin
            flushing_in = flushing_ff;
            if (req.op == OP_FLUSH && !flushing_ff && cur_col == '0) begin
               if (rows_ff != 2'd0) flushing_in = 1'b1;
            end
            if (req.op == OP_FLUSH && !flushing_ff && cur_col == '0 && rows_ff == 2'd0) begin
               st_in = S_IDLE;
            end else begin
               pix_in = (req.op == OP_FLUSH || flushing_in) ? 8'd0 : req.pixel;
               col_in = cur_col;
               last_in = ({{(13-AW){1'b0}}, cur_col} == width_eff - 13'd1);
               c0_in = (cur_col == '0);
               emit_in = (rows_ff != 2'd0);
               st_in = S_READ;
            end
         end
         S_READ: begin
            two_in = !c0_ff && last_ff;
            if (emit_ff && (!c0_ff || last_ff)) begin start = 1'b1; st_in = S_FIRST; end
            else st_in = S_OUT;
         end
         S_FIRST: begin
            st_in = S_WAIT1;
         end
         S_WAIT1: if (gdone) st_in = S_WAIT1;
         default: ;
      endcase
      if (st_ff == S_WAIT1 && out_valid_ff && rsp.ready && two_ff) begin
         start = 1'b1; st_in = S_SECOND;
      end else if (st_ff == S_WAIT1 && out_valid_ff && rsp.ready) st_in = S_OUT;
      if (st_ff == S_SECOND) st_in = S_WAIT2;
      if (st_ff == S_WAIT2 && out_valid_ff && rsp.ready) st_in = S_OUT;
      if (st_ff == S_OUT) begin
         st_in = S_IDLE;
         if (last_ff) begin
            col_in = '0;
            if (flushing_ff) begin rows_in = 2'd0; flushing_in = 1'b0; end
            else if (rows_ff < 2'd2) rows_in = rows_ff + 2'd1;
         end else col_in = col_ff + AW'(1);
      end
   end

   // window columns; col0/col1 are held from S_READ into hc0/hc1 for S_OUT
   logic [7:0] hc0_ff, hc1_ff;
   always_ff @(posedge clock) begin
      if (st_ff == S_READ) begin hc0_ff <= col0; hc1_ff <= col1; end
      if (st_ff == S_OUT) begin
         if (c0_ff) begin w_ff[0] <= 8'd0; w_ff[1] <= 8'd0; w_ff[2] <= 8'd0; end
         else begin w_ff[0] <= w_ff[3]; w_ff[1] <= w_ff[4]; w_ff[2] <= w_ff[5]; end
         w_ff[3] <= hc0_ff; w_ff[4] <= hc1_ff; w_ff[5] <= pix_ff;
      end
   end

   // sequencer state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= '0; col_ff <= '0; rows_ff <= 2'd0;
         flushing_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; col_ff <= col_in; rows_ff <= rows_in;
         flushing_ff <= flushing_in;
         if (gdone) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
      pix_ff <= pix_in; last_ff <= last_in; emit_ff <= emit_in; c0_ff <= c0_in;
      two_ff <= two_in;
      if (gdone) begin
         out_ff <= gres;
         out_last_ff <= flushing_ff && last_ff && (st_ff == S_WAIT2 || !two_ff);
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.value = out_ff;
   assign rsp.frame_last = out_last_ff;
endmodule

>>> rtl/spg_checker.sv
// Port-level checker for the gradient stream, bound to the top level.
// Depends on the top level's channel ports.
`timescale 1ns / 1ps
module spg_port_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_value
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result beat dropped while stalled");
   a_noin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("pixel taken while result stalled");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind sobel_prewitt_gradient_stream spg_port_checker u_chk (
   .clock(clock), .reset(reset), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_value(rsp.value));
